>>> design/wmfm_pkg.sv
package wmfm_pkg;

  localparam int WINDOW_MAX_DEF   = 65536;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int CNT_W    = 17;
  localparam int SAMP_W   = 32;
  localparam int EVW_W    = 32;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = 72;
  localparam int OUT_DW   = 56;

  localparam logic [2:0] OP_GE = 3'd1;
  localparam logic [2:0] OP_GT = 3'd2;
  localparam logic [2:0] OP_LE = 3'd3;
  localparam logic [2:0] OP_LT = 3'd4;
  localparam logic [2:0] OP_EQ = 3'd5;
  localparam logic [2:0] OP_NE = 3'd6;

  localparam logic [CFG_AW-1:0] CFG_COMPARE_OP = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MIN_GOOD   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_EVENT_BIT  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

>>> design/wmfm_div.sv
module wmfm_div
  import wmfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] quotient
);

  // restoring division of (dividend << 16) by divisor, dividend <= divisor,
  // one quotient bit per cycle
  localparam int STEPS = CNT_W;

  logic             busy_r;
  logic [4:0]       step_r;
  logic [CNT_W:0]   rem_r;
  logic [CNT_W:0]   div_r;
  logic [CNT_W-1:0] q_r;
  logic             done_r;
  logic             fit;
  logic [CNT_W:0]   rem_sub;

  assign fit     = rem_r >= div_r;
  assign rem_sub = fit ? (rem_r - div_r) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 5'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      div_r <= {1'b0, divisor};
    end else if (busy_r) begin
      q_r   <= {q_r[CNT_W-2:0], fit};
      rem_r <= {rem_sub[CNT_W-1:0], 1'b0};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> design/window_match_fraction_masked.sv
// window match fraction with event masking
// in_ channel: one history sample per word; in_tlast closes the window.
//   a sample is skipped when missing or when its event word is present with
//   the selected event bit set; otherwise it counts as good and is compared
//   with the threshold, a true compare counting as a match.
// out_ channel: one word per window, given after the word carrying in_tlast:
//   matched/good as unsigned Q1.16 (zero when too few good), both counts and
//   the enough flag.
// cfg_ port: single-cycle register writes; the user must make them only while
//   the block is idle, which the block itself does not enforce.
// in_ channel stays closed while the bit-serial compare shifts sample and
//   threshold one bit per cycle over 32 bits and, after the last word of a
//   window, while the division shifts one quotient bit per cycle over 17 bits,
//   until the result is loaded into the output register.
// reset: counters cleared, registers to their defaults (compare ge, rest 0).
// the result sits in an output register, so samples of the next window keep
//   flowing while the receiver stalls; only a second result waits for space.
module window_match_fraction_masked
  import wmfm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // sample_value[31:0], sample_missing[32], event_present[33], event_word[65:34]
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  // match_ratio[16:0], good_total[33:17], match_total[50:34], enough_good[51]
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int SB    = (SAMPLE_WIDTH > SAMP_W) ? SAMP_W : SAMPLE_WIDTH;
  localparam int CAP_I = (WINDOW_MAX < 131071) ? WINDOW_MAX : 131071;
  localparam logic [CNT_W-1:0] CAP = CAP_I[CNT_W-1:0];

  // configuration
  logic [2:0]        op_r;
  logic [SAMP_W-1:0] thr_r;
  logic [CNT_W-1:0]  min_good_r;
  logic [4:0]        ev_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= OP_GE;
      thr_r      <= '0;
      min_good_r <= '0;
      ev_bit_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_COMPARE_OP: op_r       <= cfg_wdata[2:0];
        CFG_THRESHOLD:  thr_r      <= cfg_wdata[SAMP_W-1:0];
        CFG_MIN_GOOD:   min_good_r <= cfg_wdata[CNT_W-1:0];
        CFG_EVENT_BIT:  ev_bit_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [SAMP_W-1:0] in_sample;
  logic              in_missing;
  logic              in_present;
  logic [EVW_W-1:0]  in_word;
  logic [SAMP_W-1:0] samp_ext;
  logic              in_good;

  assign in_sample  = in_tdata[SAMP_W-1:0];
  assign in_missing = in_tdata[SAMP_W];
  assign in_present = in_tdata[SAMP_W+1];
  assign in_word    = in_tdata[SAMP_W+2+EVW_W-1:SAMP_W+2];
  assign in_good    = !in_missing && !(in_present && in_word[ev_bit_r]);

  always_comb begin
    for (int i = 0; i < SAMP_W; i++) begin
      samp_ext[i] = (i < SB) ? in_sample[i] : in_sample[SB-1];
    end
  end

  // control
  state_t state_r, state_nxt;
  logic   in_acc;
  logic   cmp_end;
  logic   div_start;
  logic   div_done;
  logic   out_space;
  logic   out_load;

  logic [4:0]        bit_cnt_r;
  logic [SAMP_W-1:0] samp_sr_r;
  logic [SAMP_W-1:0] thr_sr_r;
  logic              lt_r, eq_r, lt_nxt, eq_nxt;
  logic              good_r, last_r;
  logic              bit_a, bit_b, hit;

  logic [CNT_W-1:0] good_cnt_r, match_cnt_r;
  logic [CNT_W-1:0] good_upd, match_upd;
  logic [CNT_W-1:0] res_good_r, res_match_r;
  logic             res_enough_r, enough_upd;
  logic [CNT_W-1:0] quotient;

  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  assign in_acc    = in_tvalid && in_tready;
  assign cmp_end   = (state_r == ST_CMP) && (bit_cnt_r == 5'd31);
  assign out_space = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_CMP;
      ST_CMP:  if (bit_cnt_r == 5'd31) state_nxt = last_r ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) state_nxt = out_space ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_space) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CMP:  div_start = (bit_cnt_r == 5'd31) && last_r;
      ST_DIV:  out_load  = div_done && out_space;
      ST_HOLD: out_load  = out_space;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // bit-serial signed compare, lsb first, sign bits flipped on the last bit
  assign bit_a  = samp_sr_r[0] ^ (bit_cnt_r == 5'd31);
  assign bit_b  = thr_sr_r[0] ^ (bit_cnt_r == 5'd31);
  assign lt_nxt = (bit_a != bit_b) ? bit_b : lt_r;
  assign eq_nxt = eq_r && (bit_a == bit_b);

  always_comb begin
    case (op_r)
      OP_GE:   hit = !lt_nxt;
      OP_GT:   hit = !lt_nxt && !eq_nxt;
      OP_LE:   hit = lt_nxt || eq_nxt;
      OP_LT:   hit = lt_nxt;
      OP_EQ:   hit = eq_nxt;
      OP_NE:   hit = !eq_nxt;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_sr_r <= samp_ext;
      thr_sr_r  <= thr_r;
      lt_r      <= 1'b0;
      eq_r      <= 1'b1;
      good_r    <= in_good;
      last_r    <= in_tlast;
      bit_cnt_r <= '0;
    end else if (state_r == ST_CMP) begin
      samp_sr_r <= {1'b0, samp_sr_r[SAMP_W-1:1]};
      thr_sr_r  <= {1'b0, thr_sr_r[SAMP_W-1:1]};
      lt_r      <= lt_nxt;
      eq_r      <= eq_nxt;
      bit_cnt_r <= bit_cnt_r + 5'd1;
    end
  end

  // saturating window counters
  always_comb begin
    good_upd  = good_cnt_r;
    match_upd = match_cnt_r;
    if (good_r) begin
      if (good_cnt_r < CAP) good_upd = good_cnt_r + CNT_W'(1);
      if (hit && match_cnt_r < CAP) match_upd = match_cnt_r + CNT_W'(1);
    end
  end

  assign enough_upd = (good_upd >= min_good_r) && (good_upd != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_cnt_r  <= '0;
      match_cnt_r <= '0;
    end else if (cmp_end) begin
      good_cnt_r  <= last_r ? '0 : good_upd;
      match_cnt_r <= last_r ? '0 : match_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      res_good_r   <= good_upd;
      res_match_r  <= match_upd;
      res_enough_r <= enough_upd;
    end
  end

  wmfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (match_upd),
    .divisor  (good_upd),
    .done     (div_done),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {4'd0, res_enough_r, res_match_r, res_good_r,
                     res_enough_r ? quotient : {CNT_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_match_le_good: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= good_cnt_r)
    else $error("match count above good count");

  a_no_ratio_when_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[51] |-> out_tdata[16:0] == '0)
    else $error("ratio given without enough good samples");

  a_cmp_runs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP && bit_cnt_r != 5'd31 |=> state_r == ST_CMP)
    else $error("compare left early");

  a_start_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> last_r && cmp_end)
    else $error("division started outside window end");

endmodule
